// ===== rtl/php_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the pes header parser
// no dependencies; used by php_front, php_fifo, php_back and the top level
package php_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  // result queue between parser and output stage
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // result kind carried on tuser
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // what one input byte leaves for the output side: a payload byte, a summary or both
  typedef struct packed {
    logic              pay_vld;
    logic [DATA_W-1:0] pay_byte;
    logic              sum_vld;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] stream_code;
    logic [DATA_W-1:0] flags;
    logic [CNT_W-1:0]  count;
  } entry_t;

endpackage

// ===== rtl/php_front.sv =====
`timescale 1ns / 1ps
// parser front: walks the pes header one byte per cycle while input bytes are accepted, builds result entries
// depends on php_pkg
module php_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_vld_i,
  input  logic [php_pkg::DATA_W-1:0] data_byte_i,
  input  logic                     last_i,
  output logic                     push_o,
  output php_pkg::entry_t          entry_o
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_FLAGS   = 3'd2;
  localparam logic [2:0] PH_HDRLEN  = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_START     = 3'd1;
  localparam logic [2:0] ST_LENGTH    = 3'd2;
  localparam logic [2:0] ST_MARKER    = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] bal_q, bal_d;
  logic        ovr_q, ovr_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  hl_q, hl_d;
  logic [2:0]  err_q, err_d;
  logic [15:0] pc_q, pc_d;

  logic        counted;
  logic [7:0]  want;
  logic [3:0]  need;
  logic [2:0]  status;
  logic        pay;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    id_d    = id_q;
    len_d   = len_q;
    bal_d   = bal_q;
    ovr_d   = ovr_q;
    flags_d = flags_q;
    hl_d    = hl_q;
    err_d   = err_q;
    pc_d    = pc_q;
    pay     = 1'b0;
    want    = (idx_q == 2'd2) ? 8'h01 : 8'h00;
    need    = (flags_q[1] ? 4'd5 : 4'd0) + (flags_q[0] ? 4'd5 : 4'd0);

    // bytes after the length field, used for the length check
    counted = (phase_q == PH_FLAGS) || (phase_q == PH_HDRLEN) || (phase_q == PH_SKIP)
           || (phase_q == PH_PAYLOAD)
           || ((phase_q == PH_ERROR) && ((err_q == ST_MARKER) || (err_q == ST_SHORT)));
    if (counted) begin
      if (bal_q == 16'hFFFF) ovr_d = 1'b1;
      else                   bal_d = bal_q + 16'd1;
    end

    unique case (phase_q)
      PH_START: begin
        if (idx_q != 2'd3) begin
          if (data_byte_i != want) begin
            err_d   = ST_START;
            phase_d = PH_ERROR;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          id_d    = data_byte_i;
          idx_d   = 2'd0;
          phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (idx_q == 2'd0) begin
          len_d = {data_byte_i, 8'h00};
          idx_d = 2'd1;
        end else begin
          len_d = {len_q[15:8], data_byte_i};
          idx_d = 2'd0;
          if ((len_d == 16'd0) && ((id_q < 8'hE0) || (id_q >= 8'hF0))) begin
            err_d   = ST_LENGTH;
            phase_d = PH_ERROR;
          end else if ((id_q == 8'hBE) || (id_q == 8'hBF)) begin
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_FLAGS;
          end
        end
      end
      PH_FLAGS: begin
        if (idx_q == 2'd0) begin
          if (data_byte_i[7:6] != 2'b10) begin
            err_d   = ST_MARKER;
            phase_d = PH_ERROR;
          end else begin
            flags_d = {data_byte_i[5:0], 2'b00};
            idx_d   = 2'd1;
          end
        end else begin
          flags_d = {flags_q[7:2], data_byte_i[7:6]};
          idx_d   = 2'd0;
          phase_d = PH_HDRLEN;
        end
      end
      PH_HDRLEN: begin
        if (data_byte_i < {4'd0, need}) begin
          err_d   = ST_SHORT;
          phase_d = PH_ERROR;
        end else begin
          hl_d    = data_byte_i;
          phase_d = (data_byte_i == 8'd0) ? PH_PAYLOAD : PH_SKIP;
        end
      end
      PH_SKIP: begin
        hl_d = hl_q - 8'd1;
        if (hl_d == 8'd0) phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pc_q != 16'hFFFF) pc_d = pc_q + 16'd1;
        pay = 1'b1;
      end
      default: begin
      end
    endcase

    // summary status, from the state this byte leaves behind
    if (err_d == ST_START)                                       status = ST_START;
    else if ((phase_d == PH_START) || (phase_d == PH_LENGTH))    status = ST_TRUNCATED;
    else if (err_d == ST_LENGTH)                                 status = ST_LENGTH;
    else if ((len_d != 16'd0) && (ovr_d || (bal_d != len_d)))   status = ST_LENGTH;
    else if (err_d != ST_OK)                                     status = err_d;
    else if ((phase_d == PH_FLAGS) || (phase_d == PH_HDRLEN) || (phase_d == PH_SKIP))
      status = ST_TRUNCATED;
    else                                                         status = ST_OK;

    entry_o.pay_vld     = pay;
    entry_o.pay_byte    = data_byte_i;
    entry_o.sum_vld     = last_i;
    entry_o.status      = status;
    entry_o.stream_code = id_d;
    entry_o.flags       = flags_d;
    entry_o.count       = pc_d;

    if (last_i) begin
      phase_d = PH_START;
      idx_d   = 2'd0;
      id_d    = 8'd0;
      len_d   = 16'd0;
      bal_d   = 16'd0;
      ovr_d   = 1'b0;
      flags_d = 8'd0;
      hl_d    = 8'd0;
      err_d   = ST_OK;
      pc_d    = 16'd0;
    end
  end

  assign push_o = byte_vld_i && (pay || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      idx_q   <= 2'd0;
      id_q    <= 8'd0;
      len_q   <= 16'd0;
      bal_q   <= 16'd0;
      ovr_q   <= 1'b0;
      flags_q <= 8'd0;
      hl_q    <= 8'd0;
      err_q   <= ST_OK;
      pc_q    <= 16'd0;
    end else if (byte_vld_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      len_q   <= len_d;
      bal_q   <= bal_d;
      ovr_q   <= ovr_d;
      flags_q <= flags_d;
      hl_q    <= hl_d;
      err_q   <= err_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// ===== rtl/php_fifo.sv =====
`timescale 1ns / 1ps
// short result queue between parser front and output stage
// depends on php_pkg
module php_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  php_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output php_pkg::entry_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  php_pkg::entry_t               mem_q [php_pkg::FIFO_DEPTH];
  logic [php_pkg::FIFO_AW-1:0]   wr_q, wr_d;
  logic [php_pkg::FIFO_AW-1:0]   rd_q, rd_d;
  logic [php_pkg::FIFO_CW-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o     = (cnt_q == php_pkg::FIFO_CW'(php_pkg::FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/php_back.sv =====
`timescale 1ns / 1ps
// output stage: holds one queue entry and hands out its payload, its summary, or its payload then its summary
// depends on php_pkg
module php_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  php_pkg::entry_t                  head_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic                             m_kind_o,
  output logic [php_pkg::OUT_TDATA_W-1:0]  m_data_o
);

  php_pkg::entry_t ent_q, ent_d;
  logic            vld_q, vld_d;
  logic            take;
  logic            done;

  assign take = vld_q && m_ready_i;
  // entry is finished when its last result leaves
  assign done = take && !(ent_q.pay_vld && ent_q.sum_vld);
  assign pop_o = !empty_i && (!vld_q || done);

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (take && !done) ent_d.pay_vld = 1'b0;
    if (done) vld_d = 1'b0;
    if (pop_o) begin
      ent_d = head_i;
      vld_d = 1'b1;
    end
  end

  assign m_valid_o = vld_q;
  assign m_kind_o  = ent_q.pay_vld ? php_pkg::KIND_PAYLOAD : php_pkg::KIND_SUMMARY;

  always_comb begin
    m_data_o = '0;
    if (ent_q.pay_vld) begin
      m_data_o[7:0] = ent_q.pay_byte;
    end else begin
      m_data_o[10:8]  = ent_q.status;
      m_data_o[18:11] = ent_q.stream_code;
      m_data_o[26:19] = ent_q.flags;
      m_data_o[42:27] = ent_q.count;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_d;
  end

endmodule

// ===== rtl/pes_header_parser.sv =====
`timescale 1ns / 1ps
// pes packet header parser top: parser front, result queue, output stage
// output path: a payload byte or summary is registered in the result queue and then
//   in the output stage register before it is offered on the output
// throughput: one input byte per cycle while the result queue is not full; a last byte
//   that is also payload gives two results, absorbed by the four-entry result queue
// reset: rst_ni asynchronous, active low; parser returns to start code search
module pes_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [10:8] parse_status, [18:11] stream_code,
  // [26:19] header_flags, [42:27] payload_count, [47:43] zero
  output logic [php_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tuser    // result_kind
);

  php_pkg::entry_t push_ent;
  php_pkg::entry_t head_ent;
  logic            push, pop, full, empty, byte_vld;

  assign s_axis_tready = !full;
  assign byte_vld      = s_axis_tvalid && s_axis_tready;

  php_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_vld_i  (byte_vld),
    .data_byte_i (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .entry_o     (push_ent)
  );

  php_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_ent),
    .pop_i       (pop),
    .pop_data_o  (head_ent),
    .full_o      (full),
    .empty_o     (empty)
  );

  php_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_ent),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_kind_o  (m_axis_tuser),
    .m_data_o  (m_axis_tdata)
  );

endmodule
